// ----- sv/sv39_ptw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sv39 page table walker package
// Shared constants, payload types and state encoding of the walker.
// ----------------------------------------------------------------------------
package sv39_ptw_pkg;

  localparam int STORE_WORDS = 4096;
  localparam int IDX_W       = $clog2(STORE_WORDS);
  localparam int ROOT_W      = 44;
  localparam int VA_W        = 39;
  localparam int PTE_W       = 64;
  localparam int PA_W        = 56;
  localparam int VPN_W       = 9;
  localparam int PPN_SHIFT   = 10;
  localparam int PAGE_SHIFT  = 12;
  localparam int PPN_W       = PTE_W - PPN_SHIFT;
  localparam int PTE_V       = 0;
  localparam int PTE_U       = 4;

  localparam logic KIND_WRITE     = 1'b0;
  localparam logic KIND_TRANSLATE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [VA_W-1:0]   address;
    logic [PTE_W-1:0]  entry_word;
  } req_t;

  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    logic            fault;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_t;

  function automatic logic [IDX_W-1:0] word_index(input logic [PPN_W-1:0] page,
                                                  input logic [VPN_W-1:0] vpn);
    logic [PPN_W+VPN_W-1:0] cat;
    cat = {page, vpn};
    return cat[IDX_W-1:0];
  endfunction

endpackage

// ----- sv/sv39_ptw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sv39_ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/sv39_page_table_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sv39 page table walker
// Walks a three-level Sv39 table held in a local page table word store.
// ----------------------------------------------------------------------------
//   Channel   Signals                          Payload
//   cfg       cfg_valid / cfg_ready            cfg_data: root page number
//   req       req_valid / req_ready            req: kind, address, entry_word
//   rsp       rsp_valid / rsp_ready            rsp: phys_addr, fault
//
// A write finishes from the idle state; a translation makes one store read
// per level through the single read port of the word store.
// After reset the store is cleared one word per cycle while req_ready
// stays low; configuration writes are taken throughout.
// A result waiting on rsp does not block the next request; the walker only
// holds when its own finished result cannot enter the output register.
// ----------------------------------------------------------------------------
module sv39_page_table_walker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sv39_ptw_pkg::ROOT_W-1:0]       cfg_data,
  input  logic                                  req_valid,
  output logic                                  req_ready,
  input  sv39_ptw_pkg::req_t                    req,
  output logic                                  rsp_valid,
  input  logic                                  rsp_ready,
  output sv39_ptw_pkg::rsp_t                    rsp
);

  sv39_ptw_pkg::state_t                   state, state_next;
  logic [1:0]                             level, level_next;
  logic [sv39_ptw_pkg::VA_W-1:0]          va, va_next;
  logic [sv39_ptw_pkg::IDX_W-1:0]         clear_idx;
  logic [sv39_ptw_pkg::ROOT_W-1:0]        root;
  sv39_ptw_pkg::rsp_t                     hold, hold_next;
  sv39_ptw_pkg::rsp_t                     result;
  logic                                   finish;
  logic                                   out_free;
  logic                                   rsp_load;
  sv39_ptw_pkg::rsp_t                     rsp_next;

  logic                                   ram_we;
  logic [sv39_ptw_pkg::IDX_W-1:0]         ram_waddr;
  logic [sv39_ptw_pkg::PTE_W-1:0]         ram_wdata;
  logic [sv39_ptw_pkg::IDX_W-1:0]         ram_raddr;
  logic [sv39_ptw_pkg::PTE_W-1:0]         ram_rdata;
  logic [sv39_ptw_pkg::VPN_W-1:0]         vpn_lower;

  sv39_ptw_ram #(
    .WIDTH(sv39_ptw_pkg::PTE_W),
    .DEPTH(sv39_ptw_pkg::STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign req_ready = (state == sv39_ptw_pkg::ST_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    case (level)
      2'd2:    vpn_lower = va[29:21];
      default: vpn_lower = va[20:12];
    endcase
  end

  always_comb begin
    state_next = state;
    level_next = level;
    va_next    = va;
    hold_next  = hold;
    result     = '0;
    finish     = 1'b0;
    rsp_load   = 1'b0;
    rsp_next   = hold;
    ram_we     = 1'b0;
    ram_waddr  = clear_idx;
    ram_wdata  = '0;
    ram_raddr  = '0;

    case (state)
      sv39_ptw_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (clear_idx == '1) begin
          state_next = sv39_ptw_pkg::ST_IDLE;
        end
      end
      sv39_ptw_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.kind == sv39_ptw_pkg::KIND_WRITE) begin
            ram_we    = 1'b1;
            ram_waddr = req.address[sv39_ptw_pkg::IDX_W-1:0];
            ram_wdata = req.entry_word;
            finish    = 1'b1;
          end else begin
            ram_raddr  = sv39_ptw_pkg::word_index(
                           sv39_ptw_pkg::PPN_W'(root), req.address[38:30]);
            va_next    = req.address;
            level_next = 2'd2;
            state_next = sv39_ptw_pkg::ST_WALK;
          end
        end
      end
      sv39_ptw_pkg::ST_WALK: begin
        if (!ram_rdata[sv39_ptw_pkg::PTE_V]) begin
          result.fault = 1'b1;
          finish       = 1'b1;
        end else if (level == 2'd0) begin
          if (!ram_rdata[sv39_ptw_pkg::PTE_U]) begin
            result.fault = 1'b1;
          end else begin
            result.phys_addr = {ram_rdata[sv39_ptw_pkg::PPN_SHIFT +: 44], va[11:0]};
          end
          finish = 1'b1;
        end else begin
          ram_raddr  = sv39_ptw_pkg::word_index(
                         ram_rdata[sv39_ptw_pkg::PTE_W-1:sv39_ptw_pkg::PPN_SHIFT],
                         vpn_lower);
          level_next = level - 2'd1;
        end
      end
      sv39_ptw_pkg::ST_HOLD: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          rsp_next   = hold;
          state_next = sv39_ptw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sv39_ptw_pkg::ST_IDLE;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        rsp_load   = 1'b1;
        rsp_next   = result;
        state_next = sv39_ptw_pkg::ST_IDLE;
      end else begin
        hold_next  = result;
        state_next = sv39_ptw_pkg::ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sv39_ptw_pkg::ST_CLEAR;
      clear_idx <= '0;
      root      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sv39_ptw_pkg::ST_CLEAR) begin
        clear_idx <= clear_idx + sv39_ptw_pkg::IDX_W'(1);
      end
      if (cfg_valid) begin
        root <= cfg_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    level <= level_next;
    va    <= va_next;
    hold  <= hold_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  a_fault_zero_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.fault |-> rsp.phys_addr == '0)
    else $error("faulting result carries a nonzero address");

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == sv39_ptw_pkg::ST_CLEAR |-> !req_ready)
    else $error("request ready during store clearing");

  a_walk_starts_top: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.kind == sv39_ptw_pkg::KIND_TRANSLATE
    |=> state == sv39_ptw_pkg::ST_WALK && level == 2'd2)
    else $error("translation did not start at the top level");

  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    state == sv39_ptw_pkg::ST_HOLD |-> rsp_valid)
    else $error("walker holding a result while the output is empty");

endmodule
